[sv/sfq_pkg.sv]
// Shared definitions for the sortable FIFO queue: sizes, command and status
// codes, and the command/status bundles between the controller and datapath.
// No dependencies.
package sfq_pkg;

    // Queue sizing
    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int DATA_W      = 32;
    localparam int POS_W       = 6;
    localparam int OCC_W       = 7;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    localparam int S_TDATA_W   = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((DATA_W + OCC_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = OP_W;
    localparam int M_TUSER_W   = ST_W + 1;

    typedef logic [SLOT_W-1:0]             slot_t;
    typedef logic [CNT_W-1:0]              count_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    // Request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_EDIT  = 3'd2,
        OP_SORT  = 3'd3,
        OP_CLEAR = 3'd4
    } opcode_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    // Source of the memory write data
    typedef enum logic [1:0] {
        WR_DIN  = 2'd0,
        WR_RD   = 2'd1,
        WR_HOLD = 2'd2
    } wr_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic    wr_en;
        slot_t   wr_idx;
        wr_sel_t wr_sel;
        logic    rd_en;
        slot_t   rd_idx;
        logic    load_v;
        logic    push;
        logic    pop;
        logic    clear;
        logic    out_load;
        status_t out_status;
        logic    out_popped;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        count_t count;
        logic   rd_gt_v;
        logic   out_free;
    } dp_stat_t;

endpackage

[sv/sortable_fifo_queue_core.sv]
// Sortable FIFO queue: a ring-buffer queue of signed values taking push,
// pop, edit, sort and clear requests. Depends on sfq_pkg, sfq_ctrl and
// sfq_datapath.
//
// Usage: each request enters on the s_ group (opcode in s_tuser, value and
// position in s_tdata) and answers with exactly one result on the m_ group
// (status and empty flag in m_tuser, popped value and occupancy in m_tdata).
// Push, edit, clear, sort of fewer than two entries and every refused
// request complete at the accepting edge; the result is valid the next cycle
// and such requests stream at one per cycle while m_tready stays high. A pop
// that succeeds first reads the head entry into the memory read register,
// then loads it into the result register. A sort runs an in-place insertion
// sort through the one read port and one write port of the queue memory,
// shifting each larger entry one slot right in turn. No new request is
// taken while a pop or sort runs. The result register frees the input side:
// a new request is accepted while the last result is being taken; a result
// still waiting with m_tready low holds off further requests. Reset empties
// the queue (head and count to zero) and drops any waiting result; the
// memory keeps its contents and needs no clearing pass.
module sortable_fifo_queue_core
    import sfq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // data_in[31:0], position[37:32], zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,   // opcode[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // data_out[31:0], occupancy[38:32], zero pad
    output logic [M_TUSER_W-1:0]  m_tuser    // status[1:0], is_empty[2]
);

    dp_cmd_t                  cmd;
    dp_stat_t                 stat;
    logic signed [DATA_W-1:0] data_in;
    logic [POS_W-1:0]         position;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] data_out;
    logic                     is_empty;
    logic [OCC_W-1:0]         occupancy;

    // Unpack the request
    assign data_in  = s_tdata[DATA_W-1:0];
    assign position = s_tdata[DATA_W +: POS_W];

    sfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .opcode   (s_tuser[OP_W-1:0]),
        .position (position),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .data_in       (data_in),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (status),
        .out_data      (data_out),
        .out_empty     (is_empty),
        .out_occupancy (occupancy)
    );

    // Pack the result
    assign m_tdata = {{(M_TDATA_W - DATA_W - OCC_W){1'b0}}, occupancy, data_out};
    assign m_tuser = {is_empty, status};

endmodule

[sv/sfq_datapath.sv]
// Datapath of the sortable FIFO queue: ring buffer memory, head and count,
// sort holding register, comparator and result register.
// Depends on sfq_pkg.
module sfq_datapath
    import sfq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat,
    input  logic signed [DATA_W-1:0]  data_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ST_W-1:0]           out_status,
    output logic signed [DATA_W-1:0]  out_data,
    output logic                      out_empty,
    output logic [OCC_W-1:0]          out_occupancy
);

    value_t                   mem [CAPACITY];
    value_t                   rd_data_reg;
    value_t                   v_reg;
    slot_t                    head_reg;
    slot_t                    head_next;
    count_t                   count_reg;
    count_t                   count_next;
    slot_t                    wr_slot;
    slot_t                    rd_slot;
    value_t                   wr_data;
    logic                     out_valid_reg;
    logic [ST_W-1:0]          out_status_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_empty_reg;
    logic [OCC_W-1:0]         out_occ_reg;

    // Add an offset to a slot, wrapping at the capacity
    function automatic slot_t wrap_slot(slot_t base, slot_t off);
        logic [SLOT_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (SLOT_W+1)'(CAPACITY))
        begin
            sum = sum - (SLOT_W+1)'(CAPACITY);
        end
        return sum[SLOT_W-1:0];
    endfunction

    assign wr_slot = wrap_slot(head_reg, cmd.wr_idx);
    assign rd_slot = wrap_slot(head_reg, cmd.rd_idx);

    // Select write data
    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_DIN:  wr_data = VALUE_WIDTH'(data_in);
            WR_RD:   wr_data = rd_data_reg;
            WR_HOLD: wr_data = v_reg;
            default: wr_data = v_reg;
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_slot];
        end
        if (cmd.load_v)
        begin
            v_reg <= rd_data_reg;
        end
    end

    // Next head and count
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        priority if (cmd.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + count_t'(1);
        end
        else if (cmd.pop)
        begin
            head_next  = wrap_slot(head_reg, slot_t'(1));
            count_next = count_reg - count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the result of a request
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_data_reg   <= cmd.out_popped ? DATA_W'(rd_data_reg) : '0;
            out_empty_reg  <= (count_next == '0);
            out_occ_reg    <= OCC_W'(count_next);
        end
    end

    assign stat.count    = count_reg;
    assign stat.rd_gt_v  = (rd_data_reg > v_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_data      = out_data_reg;
    assign out_empty     = out_empty_reg;
    assign out_occupancy = out_occ_reg;

    // Count stays within capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(CAPACITY))
        else $error("entry count beyond capacity");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before it was taken");

    // Pop only with entries held, push only with room
    a_pop_push_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop |-> count_reg != '0) and (cmd.push |-> count_reg < count_t'(CAPACITY)))
        else $error("pop on empty or push on full reached the pointers");

endmodule

[sv/sfq_ctrl.sv]
// Controller of the sortable FIFO queue: decodes requests and sequences
// pop reads and the in-place insertion sort. Depends on sfq_pkg.
module sfq_ctrl
    import sfq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   opcode,
    input  logic [POS_W-1:0]  position,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SORT_LOAD,
        S_SORT_CMP,
        S_SORT_PUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    slot_t  i_reg;
    slot_t  i_next;
    slot_t  j_reg;
    slot_t  j_next;
    logic   accept;
    logic   last_pass;

    assign in_ready  = (state_reg == S_IDLE) && stat.out_free;
    assign accept    = in_valid && in_ready;
    assign last_pass = (count_t'(i_reg) + count_t'(1)) == stat.count;

    // Decode requests and step the sort
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_OK;
                    unique case (opcode)
                        OP_PUSH:
                        begin
                            if (stat.count >= count_t'(CAPACITY))
                            begin
                                cmd.out_status = ST_PUSH_FULL;
                            end
                            else
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_idx = SLOT_W'(stat.count);
                                cmd.wr_sel = WR_DIN;
                                cmd.push   = 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (stat.count == '0)
                            begin
                                cmd.out_status = ST_POP_EMPTY;
                            end
                            else
                            begin
                                cmd.out_load = 1'b0;
                                cmd.rd_en    = 1'b1;
                                cmd.rd_idx   = '0;
                                state_next   = S_POP_WAIT;
                            end
                        end
                        OP_EDIT:
                        begin
                            if (int'(position) >= int'(stat.count))
                            begin
                                cmd.out_status = ST_BAD_INDEX;
                            end
                            else
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_idx = SLOT_W'(position);
                                cmd.wr_sel = WR_DIN;
                            end
                        end
                        OP_SORT:
                        begin
                            if (stat.count >= count_t'(2))
                            begin
                                cmd.out_load = 1'b0;
                                cmd.rd_en    = 1'b1;
                                cmd.rd_idx   = slot_t'(1);
                                i_next       = slot_t'(1);
                                state_next   = S_SORT_LOAD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                            cmd.out_status = ST_OK;
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                cmd.pop        = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_OK;
                cmd.out_popped = 1'b1;
                state_next     = S_IDLE;
            end
            S_SORT_LOAD:
            begin
                // Hold the element being inserted, fetch its left neighbour
                cmd.load_v = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = i_reg - slot_t'(1);
                j_next     = i_reg;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = j_reg;
                if (stat.rd_gt_v)
                begin
                    // Shift the larger neighbour right
                    cmd.wr_sel = WR_RD;
                    j_next     = j_reg - slot_t'(1);
                    if (j_reg == slot_t'(1))
                    begin
                        state_next = S_SORT_PUT;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = j_reg - slot_t'(2);
                    end
                end
                else
                begin
                    cmd.wr_sel = WR_HOLD;
                    if (last_pass)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_OK;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = i_reg + slot_t'(1);
                        i_next     = i_reg + slot_t'(1);
                        state_next = S_SORT_LOAD;
                    end
                end
            end
            S_SORT_PUT:
            begin
                // Drop the held element at the head
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = j_reg;
                cmd.wr_sel = WR_HOLD;
                if (last_pass)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_idx = i_reg + slot_t'(1);
                    i_next     = i_reg + slot_t'(1);
                    state_next = S_SORT_LOAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // Insertion point never passes the element being inserted
    a_j_le_i: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SORT_CMP || state_reg == S_SORT_PUT) |-> j_reg <= i_reg)
        else $error("sort insertion index beyond current element");

    // A pop that reads memory loads its result, pops the entry and returns to idle from the wait state
    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP_WAIT) |-> (cmd.out_load && cmd.pop && state_next == S_IDLE))
        else $error("pop did not complete");

endmodule
